FILE: hdl/icp_pkg.sv
package icp_pkg;

	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] MAX_CHARS = 6'd31;

	localparam int PFX_W = 6;
	localparam int ADDR_W = 32;

	localparam logic [PFX_W-1:0] DEFAULT_PREFIX_RST = 6'd24;
	localparam logic [PFX_W-1:0] PREFIX_MAX = 6'd32;
	localparam logic [PFX_W-1:0] PREFIX_SAT = 6'd63;
	localparam logic [11:0] OCTET_MAX = 12'd255;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	typedef enum logic [2:0] {
		ERR_OK     = 3'd0,
		ERR_CHAR   = 3'd1,
		ERR_OCTET  = 3'd2,
		ERR_SHAPE  = 3'd3,
		ERR_PREFIX = 3'd4
	} err_t;

	// Register index for the configuration port
	localparam logic REG_DEFAULT_PREFIX = 1'b0;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_t;

	typedef struct packed {
		logic              valid_res;
		err_t              error_kind;
		logic [ADDR_W-1:0] address;
		logic [PFX_W-1:0]  prefix_len;
		logic [ADDR_W-1:0] netmask;
	} res_t;

endpackage

FILE: hdl/ipv4_cidr_text_parser_top.sv
// Channel   | Direction | Handshake          | Payload
// s_        | in        | s_tvalid/s_tready  | tdata[7:0] char_code, tlast last_char
// m_        | out       | m_tvalid/m_tready  | tuser valid_res/error_kind, tdata addr/pfx/mask
// APB       | in        | psel/penable/pready| paddr 0: default_prefix[5:0]
//
// One character per cycle, unless a last character stalls. A character is held
// in the input register; when it advances, the parse state and, on the last
// character, the result register are updated together, which raises m_tvalid;
// the result is taken at an edge where m_tready is high.
// Reset clears all parse state and sets default_prefix to 24; no clearing pass.
// While a result waits in the output register, only a last character in the
// input register stalls; other characters keep flowing.
module ipv4_cidr_text_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [31:0] address, [37:32] prefix_len, [69:38] netmask
	output logic [3:0]  m_tuser,   // [0] valid_res, [3:1] error_kind
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                      valid_s1;
	icp_pkg::char_t            item_s1;
	logic                      adv_s1;
	logic                      out_free;
	logic [icp_pkg::PFX_W-1:0] default_prefix_q;
	icp_pkg::res_t             res_c;
	icp_pkg::res_t             res_o;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == icp_pkg::REG_DEFAULT_PREFIX) ?
		{26'd0, default_prefix_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_prefix_q <= icp_pkg::DEFAULT_PREFIX_RST;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == icp_pkg::REG_DEFAULT_PREFIX) begin
			default_prefix_q <= pwdata[icp_pkg::PFX_W-1:0];
		end
	end

	// advance unless a last character finds the result register occupied
	assign adv_s1 = valid_s1 && (!item_s1.last_char || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.char_code <= s_tdata;
			item_s1.last_char <= s_tlast;
		end
	end

	icp_parse u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (adv_s1),
		.item           (item_s1),
		.default_prefix (default_prefix_q),
		.res            (res_c)
	);

	icp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv_s1 && item_s1.last_char),
		.res_in   (res_c),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.res_q    (res_o),
		.free     (out_free)
	);

	assign m_tuser = {res_o.error_kind, res_o.valid_res};
	assign m_tdata = {2'b00, res_o.netmask, res_o.prefix_len, res_o.address};

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");

	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.last_char && m_tvalid && !m_tready) |=> valid_s1)
		else $error("last character dropped while result stalled");

endmodule

FILE: hdl/icp_parse.sv
module icp_parse (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  icp_pkg::char_t           item,
	input  logic [icp_pkg::PFX_W-1:0] default_prefix,
	output icp_pkg::res_t            res
);

	logic [7:0]                  octet_acc_q;
	logic [23:0]                 upper_octets_q;
	logic [1:0]                  dot_count_q;
	logic                        digit_seen_q;
	logic                        in_prefix_q;
	logic                        prefix_stopped_q;
	logic [icp_pkg::PFX_W-1:0]   prefix_acc_q;
	icp_pkg::err_t               error_code_q;
	logic [icp_pkg::CNT_W-1:0]   char_count_q;

	logic [7:0]                  octet_acc_n;
	logic [23:0]                 upper_octets_n;
	logic [1:0]                  dot_count_n;
	logic                        digit_seen_n;
	logic                        in_prefix_n;
	logic                        prefix_stopped_n;
	logic [icp_pkg::PFX_W-1:0]   prefix_acc_n;
	icp_pkg::err_t               error_code_n;
	icp_pkg::err_t               err_fin;
	logic [icp_pkg::CNT_W-1:0]   char_count_n;

	logic                        is_digit;
	logic [3:0]                  dig;
	logic [11:0]                 octet_v;
	logic [9:0]                  prefix_v;
	logic [icp_pkg::PFX_W-1:0]   pre;
	logic [icp_pkg::PFX_W-1:0]   shamt;

	assign is_digit = (item.char_code >= icp_pkg::CH_ZERO) && (item.char_code <= icp_pkg::CH_NINE);
	assign dig = is_digit ? item.char_code[3:0] : 4'd0;
	// times ten as shift-and-add
	assign octet_v = {1'b0, octet_acc_q, 3'b000} + {3'b000, octet_acc_q, 1'b0} + {8'd0, dig};
	assign prefix_v = {1'b0, prefix_acc_q, 3'b000} + {3'b000, prefix_acc_q, 1'b0} + {6'd0, dig};

	always_comb begin
		octet_acc_n = octet_acc_q;
		upper_octets_n = upper_octets_q;
		dot_count_n = dot_count_q;
		digit_seen_n = digit_seen_q;
		in_prefix_n = in_prefix_q;
		prefix_stopped_n = prefix_stopped_q;
		prefix_acc_n = prefix_acc_q;
		error_code_n = error_code_q;
		char_count_n = char_count_q;
		if (char_count_q < icp_pkg::MAX_CHARS) begin
			char_count_n = char_count_q + 1'b1;
			if (error_code_q != icp_pkg::ERR_OK) begin
				// hold: first error wins
			end else if (in_prefix_q) begin
				if (!prefix_stopped_q) begin
					if (is_digit) begin
						prefix_acc_n = (prefix_v > {4'd0, icp_pkg::PREFIX_SAT}) ?
							icp_pkg::PREFIX_SAT : prefix_v[icp_pkg::PFX_W-1:0];
					end else begin
						prefix_stopped_n = 1'b1;
					end
				end
			end else if (is_digit) begin
				if (octet_v > icp_pkg::OCTET_MAX) begin
					error_code_n = icp_pkg::ERR_OCTET;
				end else begin
					octet_acc_n = octet_v[7:0];
					digit_seen_n = 1'b1;
				end
			end else if (item.char_code == icp_pkg::CH_DOT) begin
				if (!digit_seen_q || dot_count_q == 2'd3) begin
					error_code_n = icp_pkg::ERR_SHAPE;
				end else begin
					upper_octets_n = {upper_octets_q[15:0], octet_acc_q};
					octet_acc_n = 8'd0;
					digit_seen_n = 1'b0;
					dot_count_n = dot_count_q + 2'd1;
				end
			end else if (item.char_code == icp_pkg::CH_SLASH) begin
				if (!digit_seen_q || dot_count_q != 2'd3) begin
					error_code_n = icp_pkg::ERR_SHAPE;
				end
				in_prefix_n = 1'b1;
			end else begin
				error_code_n = icp_pkg::ERR_CHAR;
			end
		end
	end

	// close the string
	always_comb begin
		err_fin = error_code_n;
		pre = in_prefix_n ? prefix_acc_n : default_prefix;
		if (err_fin == icp_pkg::ERR_OK && !in_prefix_n &&
		    (!digit_seen_n || dot_count_n != 2'd3)) begin
			err_fin = icp_pkg::ERR_SHAPE;
		end
		if (err_fin == icp_pkg::ERR_OK && pre > icp_pkg::PREFIX_MAX) begin
			err_fin = icp_pkg::ERR_PREFIX;
		end
		shamt = icp_pkg::PREFIX_MAX - pre;
		if (err_fin == icp_pkg::ERR_OK) begin
			res.valid_res = 1'b1;
			res.error_kind = icp_pkg::ERR_OK;
			res.address = {upper_octets_n, octet_acc_n};
			res.prefix_len = pre;
			res.netmask = (pre == '0) ? '0 : ({icp_pkg::ADDR_W{1'b1}} << shamt);
		end else begin
			res.valid_res = 1'b0;
			res.error_kind = err_fin;
			res.address = '0;
			res.prefix_len = '0;
			res.netmask = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octet_acc_q <= '0;
			upper_octets_q <= '0;
			dot_count_q <= '0;
			digit_seen_q <= 1'b0;
			in_prefix_q <= 1'b0;
			prefix_stopped_q <= 1'b0;
			prefix_acc_q <= '0;
			error_code_q <= icp_pkg::ERR_OK;
			char_count_q <= '0;
		end else if (step) begin
			if (item.last_char) begin
				octet_acc_q <= '0;
				upper_octets_q <= '0;
				dot_count_q <= '0;
				digit_seen_q <= 1'b0;
				in_prefix_q <= 1'b0;
				prefix_stopped_q <= 1'b0;
				prefix_acc_q <= '0;
				error_code_q <= icp_pkg::ERR_OK;
				char_count_q <= '0;
			end else begin
				octet_acc_q <= octet_acc_n;
				upper_octets_q <= upper_octets_n;
				dot_count_q <= dot_count_n;
				digit_seen_q <= digit_seen_n;
				in_prefix_q <= in_prefix_n;
				prefix_stopped_q <= prefix_stopped_n;
				prefix_acc_q <= prefix_acc_n;
				error_code_q <= error_code_n;
				char_count_q <= char_count_n;
			end
		end
	end

	a_ok_has_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid_res |-> res.error_kind == icp_pkg::ERR_OK)
		else $error("valid result carries an error kind");

	a_err_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid_res |-> (res.address == '0 && res.netmask == '0 && res.prefix_len == '0))
		else $error("error result with nonzero fields");

	a_prefix_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !item.last_char && in_prefix_q) |=> in_prefix_q)
		else $error("prefix mode dropped mid-string");

endmodule

FILE: hdl/icp_out_reg.sv
module icp_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  icp_pkg::res_t res_in,
	input  logic          m_tready,
	output logic          m_tvalid,
	output icp_pkg::res_t res_q,
	output logic          free
);

	logic valid_q;

	assign free = !valid_q || m_tready;
	assign m_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// payload holds until the transaction completes
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule
